@@ sv/nda_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nda_pkg
// Shared types and constants for the nodelist difference applier.
// ---------------------------------------------------------------------------
package nda_pkg;

   localparam int LineMax  = 512;
   localparam int SplitLen = LineMax - 2;
   localparam int PosW     = $clog2(LineMax + 1);
   localparam int AddrW    = $clog2(LineMax);

   localparam logic [7:0] ChEof   = 8'h1A;
   localparam logic [7:0] ChA     = 8'h41;
   localparam logic [7:0] ChD     = 8'h44;
   localparam logic [7:0] ChC     = 8'h43;
   localparam logic [7:0] ChSemi  = 8'h3B;
   localparam logic [7:0] ChColon = 8'h3A;
   localparam logic [7:0] ChNl    = 8'h0A;

   localparam logic [1:0] OpScript    = 2'd0;
   localparam logic [1:0] OpOld       = 2'd1;
   localparam logic [1:0] OpScriptEnd = 2'd2;
   localparam logic [1:0] OpOldEnd    = 2'd3;

   localparam logic [1:0] SrcScript  = 2'd0;
   localparam logic [1:0] SrcOld     = 2'd1;
   localparam logic [1:0] SrcRestart = 2'd2;
   localparam logic [1:0] SrcDone    = 2'd3;

   localparam logic [2:0] StOk       = 3'd0;
   localparam logic [2:0] StHeader   = 3'd1;
   localparam logic [2:0] StMissing  = 3'd2;
   localparam logic [2:0] StUnknown  = 3'd3;
   localparam logic [2:0] StCrc      = 3'd4;

   typedef enum logic [1:0] {
      PH_HDR_SCRIPT, PH_HDR_OLD, PH_RUN, PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      M_EXPECT, M_PARSE_A, M_PARSE_D, M_PARSE_C, M_SKIP, M_ADD, M_DROP, M_COPY
   } mode_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data;
   } req_type;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] out_byte;
      logic [1:0] next_source;
      logic       done_res;
      logic [2:0] status;
   } rsp_type;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] x;
      x = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         x = x[15] ? ((x << 1) ^ 16'h1021) : (x << 1);
      end
      return x;
   endfunction

endpackage

@@ sv/nodelist_diff_applier.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nodelist_diff_applier
// Rebuilds a new list from an old list and an edit script, checking the
// header line and a CRC-16/XMODEM over the output.
//
//   channel | direction | payload
//   req_    | in        | op, data
//   rsp_    | out       | has_byte, out_byte, next_source, done_res, status
//
// One item per cycle while req_stall is low, one registered result per item.
// The header memory read is issued ahead from the incoming compare
// index, so header compares keep the full rate; a header byte written in the
// cycle of that read is forwarded from a register.
// Reset is synchronous; no clearing pass (header memory is written before read).
// A result waiting under rsp_stall is held in a skid register; req_stall rises
// only when that register is full.
// ---------------------------------------------------------------------------
module nodelist_diff_applier (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  nda_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output nda_pkg::rsp_type rsp_data
);
   import nda_pkg::*;

   phase_type   phase_ff, phase_in;
   mode_type    mode_ff, mode_in;
   logic [PosW-1:0] hlen_ff, hlen_in, cidx_ff, cidx_in, pos_ff, pos_in;
   logic [31:0] left_ff, left_in, acc_ff, acc_in;
   logic [3:0]  flags_ff, flags_in;
   logic        first_ff, first_in, sover_ff, sover_in, oover_ff, oover_in;
   logic [15:0] crc_ff, crc_in, exp_ff, exp_in;
   logic [2:0]  fstat_ff, fstat_in;

   rsp_type     out_ff, skid_ff, res;
   logic        ov_ff, sv_ff;
   logic        take;

   logic        wr_en;
   logic [AddrW-1:0] wr_addr, rd_addr;
   logic [7:0]  rd_data;
   logic        fwd_ff;
   logic [7:0]  fwd_byte_ff;
   logic [7:0]  hdr_byte;

   // skid handshake
   assign req_stall = sv_ff;
   assign take      = req_valid && !req_stall;
   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
         sv_ff <= 1'b0;
      end else begin
         if (ov_ff && rsp_stall) begin
            if (take) begin
               sv_ff   <= 1'b1;
               skid_ff <= res;
            end
         end else if (sv_ff) begin
            out_ff <= skid_ff;
            sv_ff  <= 1'b0;
            if (take) begin
               sv_ff   <= 1'b1;
               skid_ff <= res;
            end
         end else begin
            ov_ff  <= take;
            out_ff <= res;
         end
      end
   end

   // header line memory, read ahead at the next compare index
   assign wr_en   = take && phase_ff == PH_HDR_SCRIPT && req_data.op == OpScript
                    && hlen_ff < PosW'(LineMax);
   assign wr_addr = hlen_ff[AddrW-1:0];
   assign rd_addr = cidx_in[AddrW-1:0];

   nda_ram #(.Width(8), .Depth(LineMax)) u_hdr (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(req_data.data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // forward a byte written to the entry being read in the same cycle
   always_ff @(posedge clock) begin
      if (reset) fwd_ff <= 1'b0;
      else fwd_ff <= wr_en && wr_addr == rd_addr;
      fwd_byte_ff <= req_data.data;
   end

   assign hdr_byte = fwd_ff ? fwd_byte_ff : rd_data;

   // main step logic
   always_comb begin
      logic [7:0]  c;
      logic [1:0]  op;
      logic        fin, endl;
      logic [2:0]  fs;
      logic [1:0]  r;
      logic        has;
      logic [7:0]  val;
      logic [31:0] v;
      mode_type    m;
      c = req_data.data; op = req_data.op;
      fin = 1'b0; fs = StOk; r = SrcScript; has = 1'b0; val = 8'h00;
      v = 32'd0; m = mode_ff; endl = 1'b0;
      phase_in = phase_ff; mode_in = mode_ff; hlen_in = hlen_ff; cidx_in = cidx_ff;
      pos_in = pos_ff; left_in = left_ff; acc_in = acc_ff; flags_in = flags_ff;
      first_in = first_ff; sover_in = sover_ff; oover_in = oover_ff;
      crc_in = crc_ff; exp_in = exp_ff; fstat_in = fstat_ff;
      res = '0;
      if (take) begin
         case (phase_ff)
            PH_HDR_SCRIPT: begin
               if (op == OpScript) begin
                  hlen_in = hlen_ff + 1'b1;
                  if (c == ChNl || hlen_in >= PosW'(SplitLen)) begin
                     phase_in = PH_HDR_OLD; cidx_in = '0; flags_in = '0; r = SrcOld;
                  end
               end else if (op == OpScriptEnd) begin
                  if (hlen_ff == '0) begin
                     fin = 1'b1; fs = StHeader;
                  end else begin
                     phase_in = PH_HDR_OLD; cidx_in = '0; flags_in = '0; r = SrcOld;
                  end
               end
            end
            PH_HDR_OLD: begin
               r = SrcOld;
               if (op == OpOld || op == OpOldEnd) begin
                  logic close;
                  close = 1'b0;
                  if (op == OpOld) begin
                     if (cidx_ff >= hlen_ff || hdr_byte != c) flags_in[3] = 1'b1;
                     cidx_in = cidx_ff + 1'b1;
                     close = c == ChNl || cidx_in >= PosW'(SplitLen);
                  end else if (cidx_ff == '0) begin
                     fin = 1'b1; fs = StHeader;
                  end else close = 1'b1;
                  if (close) begin
                     if (flags_in[3] || cidx_in != hlen_ff) begin
                        fin = 1'b1; fs = StHeader;
                     end else begin
                        phase_in = PH_RUN; mode_in = M_EXPECT; pos_in = '0; flags_in = '0;
                        left_in = '0; acc_in = '0; sover_in = 1'b0; oover_in = 1'b0;
                        first_in = 1'b1; crc_in = '0; exp_in = '0; r = SrcRestart;
                     end
                  end
               end
            end
            PH_RUN: begin
               logic cmd_done, add_done, old_done, ph;
               cmd_done = 1'b0; add_done = 1'b0; old_done = 1'b0; ph = 1'b0;
               endl = c == ChNl || (pos_ff + 1'b1) >= PosW'(SplitLen);
               if (mode_ff == M_EXPECT && sover_ff) begin
                  fin = 1'b1; fs = (crc_ff != exp_ff) ? StCrc : StOk;
               end else if (mode_ff <= M_ADD) begin
                  if (op == OpScript) begin
                     case (mode_ff)
                        M_EXPECT: begin
                           if (c == ChA) m = M_PARSE_A;
                           else if (c == ChD) m = M_PARSE_D;
                           else if (c == ChC) m = M_PARSE_C;
                           else if (c == ChSemi || c == ChEof) m = M_SKIP;
                           else begin fin = 1'b1; fs = StUnknown; end
                           if (!fin) begin
                              mode_in = m; flags_in = '0; acc_in = '0; pos_in = PosW'(1);
                              if (endl) begin
                                 if (m == M_SKIP) begin
                                    mode_in = M_EXPECT; pos_in = '0;
                                 end else cmd_done = 1'b1;
                              end
                           end
                        end
                        M_PARSE_A, M_PARSE_D, M_PARSE_C: begin
                           ph = 1'b1;
                           pos_in = pos_ff + 1'b1;
                           cmd_done = endl;
                        end
                        M_SKIP: begin
                           pos_in = pos_ff + 1'b1;
                           if (endl) begin pos_in = '0; mode_in = M_EXPECT; end
                        end
                        default: begin
                           has = 1'b1; val = c;
                           if (first_ff) begin
                              if (c == ChColon) begin
                                 flags_in = 4'b1000; acc_in = '0;
                              end else if (flags_ff[3]) ph = 1'b1;
                           end else crc_in = crc_step(crc_ff, c);
                           pos_in = pos_ff + 1'b1;
                           add_done = endl;
                        end
                     endcase
                  end else if (op == OpScriptEnd) begin
                     sover_in = 1'b1;
                     if (mode_ff == M_ADD) begin
                        if (pos_ff == '0) begin fin = 1'b1; fs = StMissing; end
                        else add_done = 1'b1;
                     end else if (mode_ff >= M_PARSE_A && mode_ff <= M_PARSE_C) begin
                        cmd_done = 1'b1;
                     end else begin
                        mode_in = M_EXPECT; pos_in = '0;
                        fin = 1'b1; fs = (crc_ff != exp_ff) ? StCrc : StOk;
                     end
                  end
               end else begin
                  r = SrcOld;
                  if (op == OpOld) begin
                     if (mode_ff == M_COPY) begin
                        if (pos_ff == '0 && c == ChEof) flags_in[3] = 1'b1;
                        if (!flags_in[3]) begin
                           has = 1'b1; val = c; crc_in = crc_step(crc_ff, c);
                        end
                     end
                     pos_in = pos_ff + 1'b1;
                     old_done = endl;
                  end else if (op == OpOldEnd) begin
                     oover_in = 1'b1;
                     if (pos_ff == '0) begin fin = 1'b1; fs = StMissing; end
                     else old_done = 1'b1;
                  end
               end
               // number parser: one digit per byte
               if (ph) begin
                  logic [1:0] st;
                  st = flags_ff[1:0];
                  if (st == 2'd0 && (c == 8'h20 || (c >= 8'd9 && c <= 8'd13))) begin
                  end else if (st == 2'd0 && (c == 8'h2B || c == 8'h2D)) begin
                     flags_in = {flags_ff[3], (c == 8'h2D) | flags_ff[2], 2'd1};
                  end else if (st != 2'd3) begin
                     if (c >= 8'h30 && c <= 8'h39) begin
                        acc_in = (acc_ff << 3) + (acc_ff << 1) + {28'd0, c[3:0]};
                        flags_in[1:0] = 2'd2;
                     end else flags_in[1:0] = 2'd3;
                  end
               end
               v = flags_in[2] ? (32'd0 - acc_in) : acc_in;
               if (cmd_done) begin
                  pos_in = '0; flags_in = '0; acc_in = '0; mode_in = M_EXPECT;
                  if (v != 0 && !v[31]) begin
                     left_in = v;
                     if (mode_ff == M_PARSE_A || (mode_ff == M_EXPECT && m == M_PARSE_A)) begin
                        if (sover_in) begin fin = 1'b1; fs = StMissing; end
                        else mode_in = M_ADD;
                     end else if (oover_ff) begin fin = 1'b1; fs = StMissing; end
                     else begin
                        mode_in = ((mode_ff == M_EXPECT ? m : mode_ff) == M_PARSE_D)
                                  ? M_DROP : M_COPY;
                        r = SrcOld;
                     end
                  end else if (sover_in) begin
                     fin = 1'b1; fs = (crc_ff != exp_ff) ? StCrc : StOk;
                  end
               end
               if (add_done) begin
                  pos_in = '0;
                  if (first_ff) begin
                     first_in = 1'b0;
                     if (flags_in[3]) exp_in = v[15:0];
                  end
                  flags_in = '0; acc_in = '0; left_in = left_ff - 1'b1;
                  if (left_in == 0) begin
                     mode_in = M_EXPECT;
                     if (sover_in) begin
                        fin = 1'b1; fs = (crc_in != exp_in) ? StCrc : StOk;
                     end
                  end
                  if (!fin && op == OpScriptEnd) begin fin = 1'b1; fs = StMissing; end
               end
               if (old_done) begin
                  pos_in = '0; flags_in = '0; left_in = left_ff - 1'b1;
                  r = SrcOld;
                  if (left_in == 0) begin
                     mode_in = M_EXPECT; r = SrcScript;
                     if (sover_ff && !has) begin
                        fin = 1'b1; fs = (crc_in != exp_ff) ? StCrc : StOk;
                     end
                  end
                  if (!fin && op == OpOldEnd && left_in != 0) begin
                     fin = 1'b1; fs = StMissing;
                  end
               end
            end
            default: begin
               r = SrcDone;
            end
         endcase
         if (fin) begin
            phase_in = PH_DONE; fstat_in = fs;
            res = '{has_byte: 1'b1, out_byte: ChEof, next_source: SrcDone,
                    done_res: 1'b1, status: fs};
         end else begin
            res = '{has_byte: has, out_byte: val, next_source: r,
                    done_res: 1'b0, status: fstat_ff};
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR_SCRIPT; mode_ff <= M_EXPECT;
         hlen_ff <= '0; cidx_ff <= '0; pos_ff <= '0;
         left_ff <= '0; acc_ff <= '0; flags_ff <= '0;
         first_ff <= 1'b1; sover_ff <= 1'b0; oover_ff <= 1'b0;
         crc_ff <= '0; exp_ff <= '0; fstat_ff <= '0;
      end else begin
         phase_ff <= phase_in; mode_ff <= mode_in;
         hlen_ff <= hlen_in; cidx_ff <= cidx_in; pos_ff <= pos_in;
         left_ff <= left_in; acc_ff <= acc_in; flags_ff <= flags_in;
         first_ff <= first_in; sover_ff <= sover_in; oover_ff <= oover_in;
         crc_ff <= crc_in; exp_ff <= exp_in; fstat_ff <= fstat_in;
      end
   end

   // checks
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");
   a_done_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.done_res) |-> rsp_data.next_source == SrcDone)
      else $error("finish result without finished source");
   a_phase_done: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DONE |=> phase_ff == PH_DONE)
      else $error("left finished phase");
endmodule

@@ sv/nda_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nda_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module nda_ram #(
   parameter int Width = 8,
   parameter int Depth = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
